// ===== rtl/core/pbpc_pkg.sv =====
// Package for the panel button press controller.
// Holds the field widths, register indexes, power mode codes, event bit positions and reset values.
// It depends on nothing else.
`default_nettype none

package pbpc_pkg;

	// Field widths.
	localparam int TIME_W  = 32;
	localparam int DEB_W   = 10;
	localparam int CFG_W   = 16;
	localparam int IDX_W   = 2;
	localparam int MODE_W  = 2;
	localparam int SEL_W   = 3;
	localparam int EVENT_W = 6;

	// Default number of outlet rows.
	localparam int ROW_COUNT_DEF = 8;

	// Register indexes on the configuration port.
	localparam logic [IDX_W-1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [IDX_W-1:0] REG_LONG     = 2'd1;
	localparam logic [IDX_W-1:0] REG_WINDOW   = 2'd2;
	localparam logic [IDX_W-1:0] REG_BLINK    = 2'd3;

	// Register values after reset.
	localparam logic [DEB_W-1:0] DEBOUNCE_RST = 10'd20;
	localparam logic [CFG_W-1:0] LONG_RST     = 16'd1500;
	localparam logic [CFG_W-1:0] WINDOW_RST   = 16'd10000;
	localparam logic [CFG_W-1:0] BLINK_RST    = 16'd250;

	// Power mode codes.
	localparam logic [MODE_W-1:0] MODE_RUN     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_STANDBY = 2'd1;

	// Bit positions in event_bits.
	localparam int EV_PLUS_FALL  = 0;
	localparam int EV_PLUS_RISE  = 1;
	localparam int EV_MINUS_FALL = 2;
	localparam int EV_MINUS_RISE = 3;
	localparam int EV_SET_SHORT  = 4;
	localparam int EV_SET_LONG   = 5;

	// Status of one debounced button for the current scan.
	typedef struct packed {
		logic level;
		logic fell;
		logic rose;
	} deb_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/pbpc_debounce.sv =====
// Debouncer for one active-low panel button.
// It keeps the accepted level and the time the raw level last agreed with it.
// Depends on pbpc_pkg.
`default_nettype none

module pbpc_debounce (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        raw,
	input  wire logic [pbpc_pkg::TIME_W-1:0] now,
	input  wire logic [pbpc_pkg::DEB_W-1:0]  hold_ms,
	output pbpc_pkg::deb_status_t            status
);

	logic                        stable_q;
	logic [pbpc_pkg::TIME_W-1:0] agree_q;
	logic                        differ;
	logic                        take;
	logic [pbpc_pkg::TIME_W-1:0] elapsed;

	// A differing level is taken over once it has differed long enough.
	assign differ  = (raw != stable_q);
	assign elapsed = now - agree_q;
	assign take    = differ && (elapsed >= pbpc_pkg::TIME_W'(hold_ms));

	always_comb begin
		status.level = take ? raw : stable_q;
		status.fell  = take && !raw;
		status.rose  = take && raw;
	end

	// State moves only when the scan is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= 1'b1;
			agree_q  <= '0;
		end else if (en) begin
			if (!differ) begin
				agree_q <= now;
			end
			if (take) begin
				stable_q <= raw;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/panel_button_press_controller.sv =====
// Panel button press controller: debounce of four active-low buttons, short and long
// presses, a timed row selection window and a rate-limited selection LED blink.
// Depends on pbpc_pkg and pbpc_debounce.
//
// Usage: one input word is one scan of the buttons with its millisecond time stamp,
// taken when in_valid is high and in_stall is low. Each scan gives exactly one result
// word on the output channel, taken when out_valid is high and out_stall is low.
// The scan is captured in an input register and is processed from there into the
// output register, from which its result word is offered on the output channel.
// A new scan can be accepted in every cycle while the receiver does not stall; the
// sustained rate is then one scan per cycle, set by the single pass from the input
// register to the output register.
// When the receiver stalls, the output register holds its word, the input register
// holds the next scan, and in_stall rises until the output word is taken.
// Reset (arst_n low) releases all buttons, clears all timers, closes the window,
// selects row zero and loads the default register values. The user must write registers on
// the plain write port only while no scan is in flight; the block does not enforce this.
`default_nettype none

module panel_button_press_controller #(
	parameter int ROW_COUNT = pbpc_pkg::ROW_COUNT_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// Configuration port.
	input  wire logic                         cfg_we,
	input  wire logic [pbpc_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [pbpc_pkg::CFG_W-1:0]   cfg_data,
	// Scan input channel.
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [pbpc_pkg::TIME_W-1:0]  time_ms,
	input  wire logic                         plus_level,
	input  wire logic                         minus_level,
	input  wire logic                         set_level,
	input  wire logic                         power_level,
	input  wire logic [pbpc_pkg::MODE_W-1:0]  power_mode,
	input  wire logic                         blink_tick,
	// Result output channel.
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [pbpc_pkg::SEL_W-1:0]        selected_row,
	output logic                              window_active,
	output logic                              led_on,
	output logic [pbpc_pkg::EVENT_W-1:0]      event_bits,
	output logic                              enter_standby,
	output logic                              exit_standby,
	output logic                              toggle_relay,
	output logic                              clear_faults
);

	localparam int RW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
	localparam logic [RW-1:0] ROW_LAST = RW'(ROW_COUNT - 1);

	// Configuration registers.
	logic [pbpc_pkg::DEB_W-1:0] debounce_q;
	logic [pbpc_pkg::CFG_W-1:0] long_q;
	logic [pbpc_pkg::CFG_W-1:0] window_to_q;
	logic [pbpc_pkg::CFG_W-1:0] blink_per_q;

	// Input register.
	logic                          valid_s1;
	logic [pbpc_pkg::TIME_W-1:0]   time_s1;
	logic                          plus_s1;
	logic                          minus_s1;
	logic                          set_s1;
	logic                          power_s1;
	logic [pbpc_pkg::MODE_W-1:0]   mode_s1;
	logic                          tick_s1;

	// Controller state.
	logic [pbpc_pkg::TIME_W-1:0]   set_start_q;
	logic [pbpc_pkg::TIME_W-1:0]   pwr_start_q;
	logic                          set_pend_q;
	logic                          pwr_pend_q;
	logic [RW-1:0]                 row_q;
	logic                          window_q;
	logic [pbpc_pkg::TIME_W-1:0]   last_press_q;
	logic                          phase_q;
	logic [pbpc_pkg::TIME_W-1:0]   last_blink_q;

	// Next-state and result values of the current scan.
	logic [pbpc_pkg::TIME_W-1:0]   set_start_n;
	logic [pbpc_pkg::TIME_W-1:0]   pwr_start_n;
	logic                          set_pend_n;
	logic                          pwr_pend_n;
	logic [RW-1:0]                 row_n;
	logic                          window_n;
	logic [pbpc_pkg::TIME_W-1:0]   last_press_n;
	logic                          phase_n;
	logic [pbpc_pkg::TIME_W-1:0]   last_blink_n;
	logic [pbpc_pkg::EVENT_W-1:0]  ev_n;
	logic                          enter_n;
	logic                          exit_n;
	logic                          toggle_n;
	logic                          clear_n;
	logic [31:0]                   row_wide;

	logic                          advance;
	pbpc_pkg::deb_status_t         plus_st;
	pbpc_pkg::deb_status_t         minus_st;
	pbpc_pkg::deb_status_t         set_st;
	pbpc_pkg::deb_status_t         pwr_st;

	// Handshake: the scan in the input register is processed when the output register
	// is free or is being emptied in this cycle.
	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Configuration write port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q  <= pbpc_pkg::DEBOUNCE_RST;
			long_q      <= pbpc_pkg::LONG_RST;
			window_to_q <= pbpc_pkg::WINDOW_RST;
			blink_per_q <= pbpc_pkg::BLINK_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pbpc_pkg::REG_DEBOUNCE: debounce_q  <= cfg_data[pbpc_pkg::DEB_W-1:0];
				pbpc_pkg::REG_LONG:     long_q      <= cfg_data;
				pbpc_pkg::REG_WINDOW:   window_to_q <= cfg_data;
				pbpc_pkg::REG_BLINK:    blink_per_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			time_s1  <= time_ms;
			plus_s1  <= plus_level;
			minus_s1 <= minus_level;
			set_s1   <= set_level;
			power_s1 <= power_level;
			mode_s1  <= power_mode;
			tick_s1  <= blink_tick;
		end
	end

	// One debouncer per button.
	pbpc_debounce u_deb_plus (
		.clk(clk), .arst_n(arst_n), .en(advance), .raw(plus_s1), .now(time_s1),
		.hold_ms(debounce_q), .status(plus_st)
	);

	pbpc_debounce u_deb_minus (
		.clk(clk), .arst_n(arst_n), .en(advance), .raw(minus_s1), .now(time_s1),
		.hold_ms(debounce_q), .status(minus_st)
	);

	pbpc_debounce u_deb_set (
		.clk(clk), .arst_n(arst_n), .en(advance), .raw(set_s1), .now(time_s1),
		.hold_ms(debounce_q), .status(set_st)
	);

	pbpc_debounce u_deb_pwr (
		.clk(clk), .arst_n(arst_n), .en(advance), .raw(power_s1), .now(time_s1),
		.hold_ms(debounce_q), .status(pwr_st)
	);

	// Scan processing: blink service, power button, then the run-mode buttons.
	always_comb begin
		logic [pbpc_pkg::TIME_W-1:0] blink_gap;
		logic [pbpc_pkg::TIME_W-1:0] idle_gap;
		logic [pbpc_pkg::TIME_W-1:0] pwr_held;
		logic [pbpc_pkg::TIME_W-1:0] set_held;
		logic                        in_run;

		blink_gap = time_s1 - last_blink_q;
		idle_gap  = time_s1 - last_press_q;
		in_run    = (mode_s1 == pbpc_pkg::MODE_RUN);

		row_n        = row_q;
		window_n     = window_q;
		last_press_n = last_press_q;
		phase_n      = phase_q;
		last_blink_n = last_blink_q;
		ev_n         = '0;
		enter_n      = 1'b0;
		exit_n       = 1'b0;
		toggle_n     = 1'b0;
		clear_n      = 1'b0;

		// Blink service, skipped when the tick comes too soon.
		if (tick_s1 && (blink_gap >= pbpc_pkg::TIME_W'(blink_per_q[pbpc_pkg::CFG_W-1:1]))) begin
			last_blink_n = time_s1;
			if (window_q && (idle_gap >= pbpc_pkg::TIME_W'(window_to_q))) begin
				window_n = 1'b0;
				phase_n  = 1'b0;
			end else if (window_q) begin
				phase_n = !phase_q;
			end else begin
				phase_n = 1'b0;
			end
		end

		// A taken level change restarts the press timer of SET and PWR.
		set_start_n = (set_st.fell || set_st.rose) ? time_s1 : set_start_q;
		pwr_start_n = (pwr_st.fell || pwr_st.rose) ? time_s1 : pwr_start_q;
		pwr_held    = time_s1 - pwr_start_n;
		set_held    = time_s1 - set_start_n;

		// Power button: long press asks for standby in run, short press exits standby.
		pwr_pend_n = pwr_pend_q || pwr_st.fell;
		if (!pwr_st.level && pwr_pend_n && (pwr_held >= pbpc_pkg::TIME_W'(long_q))) begin
			pwr_pend_n = 1'b0;
			if (in_run) begin
				enter_n  = 1'b1;
				window_n = 1'b0;
				phase_n  = 1'b0;
			end
		end
		if (pwr_st.rose && pwr_pend_n) begin
			pwr_pend_n = 1'b0;
			if (mode_s1 == pbpc_pkg::MODE_STANDBY) begin
				exit_n = 1'b1;
			end
		end

		set_pend_n = set_pend_q;
		if (in_run) begin
			// PLUS opens the window or steps the row forward.
			if (plus_st.fell) begin
				if (!window_n) begin
					window_n     = 1'b1;
					last_press_n = time_s1;
					phase_n      = 1'b1;
					last_blink_n = time_s1;
				end else begin
					row_n        = (row_n == ROW_LAST) ? '0 : row_n + RW'(1);
					last_press_n = time_s1;
				end
				ev_n[pbpc_pkg::EV_PLUS_FALL] = 1'b1;
			end
			ev_n[pbpc_pkg::EV_PLUS_RISE] = plus_st.rose;

			// MINUS opens the window or steps the row back.
			if (minus_st.fell) begin
				if (!window_n) begin
					window_n     = 1'b1;
					last_press_n = time_s1;
					phase_n      = 1'b1;
					last_blink_n = time_s1;
				end else begin
					row_n        = (row_n == '0) ? ROW_LAST : row_n - RW'(1);
					last_press_n = time_s1;
				end
				ev_n[pbpc_pkg::EV_MINUS_FALL] = 1'b1;
			end
			ev_n[pbpc_pkg::EV_MINUS_RISE] = minus_st.rose;

			// SET long clears faults; SET short opens the window or toggles the relay.
			set_pend_n = set_pend_n || set_st.fell;
			if (!set_st.level && set_pend_n && (set_held >= pbpc_pkg::TIME_W'(long_q))) begin
				set_pend_n                  = 1'b0;
				clear_n                     = 1'b1;
				ev_n[pbpc_pkg::EV_SET_LONG] = 1'b1;
				window_n                    = 1'b0;
				phase_n                     = 1'b0;
			end
			if (set_st.rose && set_pend_n) begin
				set_pend_n = 1'b0;
				if (!window_n) begin
					window_n     = 1'b1;
					last_press_n = time_s1;
					phase_n      = 1'b1;
					last_blink_n = time_s1;
				end else begin
					last_press_n                 = time_s1;
					toggle_n                     = 1'b1;
					ev_n[pbpc_pkg::EV_SET_SHORT] = 1'b1;
				end
			end
		end
	end

	assign row_wide = 32'(row_n);

	// Controller state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_start_q  <= '0;
			pwr_start_q  <= '0;
			set_pend_q   <= 1'b0;
			pwr_pend_q   <= 1'b0;
			row_q        <= '0;
			window_q     <= 1'b0;
			last_press_q <= '0;
			phase_q      <= 1'b0;
			last_blink_q <= '0;
		end else if (advance) begin
			set_start_q  <= set_start_n;
			pwr_start_q  <= pwr_start_n;
			set_pend_q   <= set_pend_n;
			pwr_pend_q   <= pwr_pend_n;
			row_q        <= row_n;
			window_q     <= window_n;
			last_press_q <= last_press_n;
			phase_q      <= phase_n;
			last_blink_q <= last_blink_n;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || !out_stall) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			selected_row  <= row_wide[pbpc_pkg::SEL_W-1:0];
			window_active <= window_n;
			led_on        <= window_n && phase_n;
			event_bits    <= ev_n;
			enter_standby <= enter_n;
			exit_standby  <= exit_n;
			toggle_relay  <= toggle_n;
			clear_faults  <= clear_n;
		end
	end

	// A long SET press and a short SET press never resolve in the same scan.
	a_set_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(toggle_relay && clear_faults))
		else $error("toggle_relay and clear_faults in the same word");

	// Standby entry and exit need different power modes.
	a_standby_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(enter_standby && exit_standby))
		else $error("enter_standby and exit_standby in the same word");

	// The LED is only lit while the window is open.
	a_led_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!led_on || window_active))
		else $error("led_on with the window closed");

	// The SET event bits follow the relay and fault pulses.
	a_set_events: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((event_bits[pbpc_pkg::EV_SET_SHORT] == toggle_relay) &&
			(event_bits[pbpc_pkg::EV_SET_LONG] == clear_faults)))
		else $error("SET event bits disagree with the pulses");

	// The input side only stalls while a scan waits in the input register.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall))
		else $error("input stalled without a waiting scan");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Testbench for panel_button_press_controller: directed and random scan words,
// checked word by word against a built-in model held in a small scoreboard class.
// Depends on pbpc_pkg and the controller RTL.

module tb;
	import pbpc_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int ROWS         = ROW_COUNT_DEF;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 250;
	localparam int CALM_PHASE   = 4;
	localparam int HOLD_PHASE   = 5;
	localparam int HOLD_CYCLES  = 60;
	localparam int MAX_REPORTS  = 10;

	// Button slots and the two buttons that can be held long.
	localparam int BTN_PLUS  = 0;
	localparam int BTN_MINUS = 1;
	localparam int BTN_SET   = 2;
	localparam int BTN_PWR   = 3;
	localparam int HOLD_SET  = 0;
	localparam int HOLD_PWR  = 1;

	// Power states that the package leaves unnamed.
	localparam logic [MODE_W-1:0] MODE_OTHER = 2'd2;
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	typedef enum int {CHG_NONE, CHG_FALL, CHG_RISE} level_change_t;

	typedef struct packed {
		logic [TIME_W-1:0] stamp;
		logic              plus_lvl;
		logic              minus_lvl;
		logic              set_lvl;
		logic              pwr_lvl;
		logic [MODE_W-1:0] mode;
		logic              tick;
	} scan_t;

	typedef struct packed {
		logic [SEL_W-1:0]   row;
		logic               window;
		logic               led;
		logic [EVENT_W-1:0] events;
		logic               enter_sb;
		logic               exit_sb;
		logic               toggle;
		logic               clear;
	} result_t;

	// Tracks the controller state and the result words still awaited.
	class press_scoreboard;
		logic [DEB_W-1:0] deb_ms;
		logic [CFG_W-1:0] long_ms;
		logic [CFG_W-1:0] win_ms;
		logic [CFG_W-1:0] blink_ms;
		bit               stable[4];
		bit [31:0]        agree_at[4];
		bit [31:0]        press_at[2];
		bit               held[2];
		int unsigned      row;
		bit               win_open;
		bit [31:0]        last_press_at;
		bit               phase;
		bit [31:0]        last_blink_at;
		result_t          awaited_results[$];
		int               errors;
		int               words_seen;

		function new();
			deb_ms = DEBOUNCE_RST;
			long_ms = LONG_RST;
			win_ms = WINDOW_RST;
			blink_ms = BLINK_RST;
			foreach (stable[i]) begin
				stable[i] = 1'b1;
				agree_at[i] = '0;
			end
			foreach (held[i]) begin
				held[i] = 1'b0;
				press_at[i] = '0;
			end
			row = 0;
			win_open = 1'b0;
			last_press_at = '0;
			phase = 1'b0;
			last_blink_at = '0;
			errors = 0;
			words_seen = 0;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_DEBOUNCE: deb_ms = val[DEB_W-1:0];
				REG_LONG:     long_ms = val;
				REG_WINDOW:   win_ms = val;
				REG_BLINK:    blink_ms = val;
				default:      ;
			endcase
		endfunction

		function int pending();
			return awaited_results.size();
		endfunction

		// Time differences wrap modulo 2^32.
		function bit [31:0] elapsed(bit [31:0] now, bit [31:0] from_t);
			return now - from_t;
		endfunction

		function void open_window(bit [31:0] now);
			win_open = 1'b1;
			last_press_at = now;
			phase = 1'b1;
			last_blink_at = now;
		endfunction

		function void shut_window();
			win_open = 1'b0;
			phase = 1'b0;
		endfunction

		// A tick that comes too soon is dropped; otherwise it may close the window.
		function void service_blink(bit [31:0] now);
			if (elapsed(now, last_blink_at) < (blink_ms >> 1))
				return;
			last_blink_at = now;
			if (win_open && elapsed(now, last_press_at) >= win_ms) begin
				shut_window();
				return;
			end
			if (win_open)
				phase = ~phase;
			else
				phase = 1'b0;
		endfunction

		// A differing level is taken once it has differed for the debounce time.
		function level_change_t debounce_one(int b, bit raw, bit [31:0] now);
			if (raw != stable[b]) begin
				if (elapsed(now, agree_at[b]) >= deb_ms) begin
					stable[b] = raw;
					if (b == BTN_SET)
						press_at[HOLD_SET] = now;
					if (b == BTN_PWR)
						press_at[HOLD_PWR] = now;
					return raw ? CHG_RISE : CHG_FALL;
				end
			end else begin
				agree_at[b] = now;
			end
			return CHG_NONE;
		endfunction

		// Predicts the result word of one accepted scan word.
		function void note_scan(scan_t s);
			bit [31:0]     now;
			level_change_t c_plus, c_minus, c_set, c_pwr;
			result_t       r;
			now = s.stamp;
			r = '0;
			if (s.tick)
				service_blink(now);
			c_plus = debounce_one(BTN_PLUS, s.plus_lvl, now);
			c_minus = debounce_one(BTN_MINUS, s.minus_lvl, now);
			c_set = debounce_one(BTN_SET, s.set_lvl, now);
			c_pwr = debounce_one(BTN_PWR, s.pwr_lvl, now);

			// Power button: long press asks for standby, short press leaves it.
			if (c_pwr == CHG_FALL)
				held[HOLD_PWR] = 1'b1;
			if (!stable[BTN_PWR] && held[HOLD_PWR] &&
			    elapsed(now, press_at[HOLD_PWR]) >= long_ms) begin
				held[HOLD_PWR] = 1'b0;
				if (s.mode == MODE_RUN) begin
					r.enter_sb = 1'b1;
					shut_window();
				end
			end
			if (c_pwr == CHG_RISE && held[HOLD_PWR]) begin
				held[HOLD_PWR] = 1'b0;
				if (s.mode == MODE_STANDBY)
					r.exit_sb = 1'b1;
			end

			// Row selection and relay control act only in run.
			if (s.mode == MODE_RUN) begin
				if (c_plus == CHG_FALL) begin
					if (!win_open) begin
						open_window(now);
					end else begin
						row = (row + 1) % ROWS;
						last_press_at = now;
					end
					r.events[EV_PLUS_FALL] = 1'b1;
				end
				if (c_plus == CHG_RISE)
					r.events[EV_PLUS_RISE] = 1'b1;
				if (c_minus == CHG_FALL) begin
					if (!win_open) begin
						open_window(now);
					end else begin
						row = (row + ROWS - 1) % ROWS;
						last_press_at = now;
					end
					r.events[EV_MINUS_FALL] = 1'b1;
				end
				if (c_minus == CHG_RISE)
					r.events[EV_MINUS_RISE] = 1'b1;
				if (c_set == CHG_FALL)
					held[HOLD_SET] = 1'b1;
				if (!stable[BTN_SET] && held[HOLD_SET] &&
				    elapsed(now, press_at[HOLD_SET]) >= long_ms) begin
					held[HOLD_SET] = 1'b0;
					r.clear = 1'b1;
					r.events[EV_SET_LONG] = 1'b1;
					shut_window();
				end
				if (c_set == CHG_RISE && held[HOLD_SET]) begin
					held[HOLD_SET] = 1'b0;
					if (!win_open) begin
						open_window(now);
					end else begin
						last_press_at = now;
						r.toggle = 1'b1;
						r.events[EV_SET_SHORT] = 1'b1;
					end
				end
			end

			r.row = SEL_W'(row);
			r.window = win_open;
			r.led = win_open & phase;
			awaited_results.push_back(r);
		endfunction

		function string show(result_t r);
			return $sformatf("row=%0d win=%0d led=%0d ev=%02h enter=%0d exit=%0d tog=%0d clr=%0d",
				r.row, r.window, r.led, r.events, r.enter_sb, r.exit_sb, r.toggle, r.clear);
		endfunction

		// Compares one accepted result word with the oldest prediction.
		function void check_result(result_t got);
			result_t want;
			string   bad;
			words_seen++;
			if (awaited_results.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected result word %0d: %s", words_seen, show(got));
				return;
			end
			want = awaited_results.pop_front();
			bad = "";
			if (got.row !== want.row)
				bad = {bad, " selected_row"};
			if (got.window !== want.window)
				bad = {bad, " window_active"};
			if (got.led !== want.led)
				bad = {bad, " led_on"};
			if (got.events !== want.events)
				bad = {bad, " event_bits"};
			if (got.enter_sb !== want.enter_sb)
				bad = {bad, " enter_standby"};
			if (got.exit_sb !== want.exit_sb)
				bad = {bad, " exit_standby"};
			if (got.toggle !== want.toggle)
				bad = {bad, " toggle_relay"};
			if (got.clear !== want.clear)
				bad = {bad, " clear_faults"};
			if (bad != "") begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("word %0d differs in%s\n  expected %s\n  actual   %s",
						words_seen, bad, show(want), show(got));
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [IDX_W-1:0]    cfg_index;
	logic [CFG_W-1:0]    cfg_data;
	logic                in_valid;
	logic                in_stall;
	logic [TIME_W-1:0]   time_ms;
	logic                plus_level;
	logic                minus_level;
	logic                set_level;
	logic                power_level;
	logic [MODE_W-1:0]   power_mode;
	logic                blink_tick;
	logic                out_valid;
	logic                out_stall;
	logic [SEL_W-1:0]    selected_row;
	logic                window_active;
	logic                led_on;
	logic [EVENT_W-1:0]  event_bits;
	logic                enter_standby;
	logic                exit_standby;
	logic                toggle_relay;
	logic                clear_faults;

	press_scoreboard sb;
	bit              calm;
	bit              hold_request;
	int              cycle_count;

	panel_button_press_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.time_ms(time_ms),
		.plus_level(plus_level),
		.minus_level(minus_level),
		.set_level(set_level),
		.power_level(power_level),
		.power_mode(power_mode),
		.blink_tick(blink_tick),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.selected_row(selected_row),
		.window_active(window_active),
		.led_on(led_on),
		.event_bits(event_bits),
		.enter_standby(enter_standby),
		.exit_standby(exit_standby),
		.toggle_relay(toggle_relay),
		.clear_faults(clear_faults)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Note accepted scan words and check accepted result words at the rising edge.
	always @(posedge clk) begin
		if (arst_n && sb != null) begin
			if (in_valid && !in_stall)
				sb.note_scan({time_ms, plus_level, minus_level, set_level, power_level,
					power_mode, blink_tick});
			if (out_valid && !out_stall)
				sb.check_result({selected_row, window_active, led_on, event_bits,
					enter_standby, exit_standby, toggle_relay, clear_faults});
		end
	end

	// Guard against a hang.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Receiver: random stalls, none while calm, and one long hold-off on request.
	initial begin
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else if (calm) begin
				out_stall = 1'b0;
			end else begin
				out_stall = ($urandom_range(99) < 27);
			end
		end
	end

	// Offers one scan word from a falling edge and returns at the falling edge after
	// it was taken, with in_valid still high.
	task automatic drive_scan(input scan_t s);
		while (!calm && $urandom_range(99) < 27) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		{time_ms, plus_level, minus_level, set_level, power_level, power_mode, blink_tick} = s;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	// Levels are given as {plus, minus, set, pwr}, 1 meaning released.
	task automatic scan_at(input logic [31:0] t, input logic [3:0] lv,
	                       input logic [MODE_W-1:0] mode, input logic tick);
		drive_scan({t, lv, mode, tick});
	endtask

	task automatic program_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Stop offering and let every awaited word arrive.
	task automatic drain();
		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		logic [CFG_W-1:0]  deb, lng, win, blk;
		int unsigned       step;
		logic [31:0]       now;
		logic [3:0]        lv;
		logic [MODE_W-1:0] mode;
		int unsigned       pick;

		sb = new();
		calm = 1'b0;
		hold_request = 1'b0;
		cycle_count = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_DEBOUNCE;
		cfg_data = '0;
		in_valid = 1'b0;
		{time_ms, plus_level, minus_level, set_level, power_level, power_mode, blink_tick} = '1;
		power_mode = MODE_RUN;
		blink_tick = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed scans at the reset register values.
		scan_at(32'd0,     4'b1111, MODE_RUN, 1'b1);  // tick with the window closed
		scan_at(32'd10,    4'b0111, MODE_RUN, 1'b0);  // plus bounce, too short
		scan_at(32'd25,    4'b0111, MODE_RUN, 1'b0);  // plus fall opens the window
		scan_at(32'd60,    4'b1111, MODE_RUN, 1'b0);
		scan_at(32'd100,   4'b0111, MODE_RUN, 1'b0);  // plus steps the row
		scan_at(32'd140,   4'b1011, MODE_RUN, 1'b0);  // minus steps back
		scan_at(32'd200,   4'b1011, MODE_RUN, 1'b1);  // blink toggles
		scan_at(32'd210,   4'b1011, MODE_RUN, 1'b1);  // tick too soon
		scan_at(32'd260,   4'b1111, MODE_RUN, 1'b0);
		scan_at(32'd300,   4'b1011, MODE_RUN, 1'b0);  // minus wraps below row zero
		scan_at(32'd340,   4'b1101, MODE_RUN, 1'b0);
		scan_at(32'd400,   4'b1111, MODE_RUN, 1'b0);  // set short toggles the relay
		scan_at(32'd500,   4'b1101, MODE_RUN, 1'b0);
		scan_at(32'd2100,  4'b1101, MODE_RUN, 1'b0);  // set long clears faults
		scan_at(32'd2200,  4'b1111, MODE_RUN, 1'b0);
		scan_at(32'd2300,  4'b1101, MODE_RUN, 1'b0);
		scan_at(32'd2350,  4'b1111, MODE_RUN, 1'b0);  // set short with window closed
		scan_at(32'd13000, 4'b1111, MODE_RUN, 1'b1);  // window times out
		scan_at(32'd13100, 4'b1110, MODE_RUN, 1'b0);
		scan_at(32'd14700, 4'b1110, MODE_RUN, 1'b0);  // power long in run
		scan_at(32'd14900, 4'b1110, MODE_STANDBY, 1'b0);
		scan_at(32'd15000, 4'b1111, MODE_STANDBY, 1'b0);
		scan_at(32'd15100, 4'b0110, MODE_OTHER, 1'b0); // no action outside run
		scan_at(32'd16700, 4'b0110, MODE_SPARE, 1'b0); // power long dropped
		scan_at(32'hFFFF_FFF0, 4'b1101, MODE_RUN, 1'b1);
		scan_at(32'h0000_0010, 4'b1111, MODE_RUN, 1'b0); // time wraps

		now = 32'h0000_0010;
		lv = 4'b1111;
		mode = MODE_RUN;
		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p)
				0: begin deb = 16'd0;    lng = 16'd1;     win = 16'd1;     blk = 16'd2;     step = 4;   end
				1: begin deb = 16'd5;    lng = 16'd40;    win = 16'd300;   blk = 16'd20;    step = 8;   end
				2: begin deb = 16'd20;   lng = 16'd150;   win = 16'd1000;  blk = 16'd60;    step = 15;  end
				3: begin deb = 16'd1000; lng = 16'd65535; win = 16'd65535; blk = 16'd65535; step = 400; end
				4: begin deb = 16'd3;    lng = 16'd25;    win = 16'd120;   blk = 16'd9;     step = 6;   end
				5: begin deb = 16'd10;   lng = 16'd80;    win = 16'd500;   blk = 16'd40;    step = 10;  end
				6: begin
					deb = 16'($urandom_range(0, 40));
					lng = 16'($urandom_range(1, 200));
					win = 16'($urandom_range(1, 2000));
					blk = 16'($urandom_range(2, 100));
					step = $urandom_range(1, 20);
				end
				// Upper data bits beyond the debounce width are dropped.
				default: begin deb = 16'hFC0A; lng = 16'd60; win = 16'd400; blk = 16'd30; step = 10; end
			endcase
			program_reg(REG_DEBOUNCE, deb);
			program_reg(REG_LONG, lng);
			program_reg(REG_WINDOW, win);
			program_reg(REG_BLINK, blk);
			calm = (p == CALM_PHASE);
			if (p == HOLD_PHASE)
				hold_request = 1'b1;

			// Buttons are held for a while and flip now and then; rare big time jumps.
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(63) == 0)
					now = now + $urandom();
				else
					now = now + $urandom_range(0, step);
				for (int b = 0; b < 4; b++)
					if ($urandom_range(5) == 0)
						lv[b] = ~lv[b];
				if ($urandom_range(24) == 0) begin
					pick = $urandom_range(99);
					if (pick < 60)
						mode = MODE_RUN;
					else if (pick < 85)
						mode = MODE_STANDBY;
					else if (pick < 93)
						mode = MODE_OTHER;
					else
						mode = MODE_SPARE;
				end
				scan_at(now, lv, mode, $urandom_range(2) == 0);
			end
		end

		calm = 1'b0;
		drain();
		repeat (10) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== panel_button_press_controller.f =====
rtl/core/pbpc_pkg.sv
rtl/core/pbpc_debounce.sv
rtl/core/panel_button_press_controller.sv
test/tb.sv
